// ===== rtl/core/scpr_pkg.sv =====
// Package for the second-chance page replacer: sizes, the sequencer state type,
// the structs passed between the modules and the field conversion helpers.
// No dependencies.
`default_nettype none

package scpr_pkg;

    localparam int FRAMES        = 4;
    localparam int PAGE_BITS     = 16;
    localparam int SLOT_BITS     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS      = $clog2(FRAMES + 1);
    localparam int IN_PAGE_BITS  = 16;
    localparam int OUT_PAGE_BITS = 16;
    localparam int OUT_SLOT_BITS = 2;
    localparam int FAULT_BITS    = 32;
    localparam int S_TDATA_BITS  = 16;
    localparam int M_FIELD_BITS  = 2 + OUT_PAGE_BITS + OUT_SLOT_BITS + FAULT_BITS;
    localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS    = M_TDATA_BITS - M_FIELD_BITS;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [FAULT_BITS-1:0] fault_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SWEEP,
        ST_EVICT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic  we;
        slot_t waddr;
        page_t wdata;
        slot_t raddr;
    } mem_req_t;

    typedef struct packed {
        fault_t                   faults_so_far;
        logic [OUT_SLOT_BITS-1:0] slot_index;
        logic [OUT_PAGE_BITS-1:0] evicted_page;
        logic                     evicted_valid;
        logic                     hit;
    } result_t;

    // The requested page is kept in PAGE_BITS bits.
    function automatic page_t page_of_word(input logic [IN_PAGE_BITS-1:0] w);
        logic [63:0] x;
        x = 64'(w);
        return x[PAGE_BITS-1:0];
    endfunction

    function automatic logic [OUT_PAGE_BITS-1:0] word_of_page(input page_t p);
        logic [63:0] x;
        x = 64'(p);
        return x[OUT_PAGE_BITS-1:0];
    endfunction

    function automatic logic [OUT_SLOT_BITS-1:0] slot_field(input slot_t s);
        logic [31:0] x;
        x = 32'(s);
        return x[OUT_SLOT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scpr_page_ram.sv =====
// Page slot memory: one write port and one read port, read data registered.
// Depends on scpr_pkg.
`default_nettype none

module scpr_page_ram (
    input  wire logic              aclk,
    input  wire scpr_pkg::mem_req_t req,
    output scpr_pkg::page_t        rdata
);

    scpr_pkg::page_t page_mem [scpr_pkg::FRAMES];
    scpr_pkg::page_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            page_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= page_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scpr_ctrl.sv =====
// Sequencer for the page replacer: hit search over the slot memory, fill,
// clock sweep over the reference bits and eviction. Depends on scpr_pkg.
`default_nettype none

module scpr_ctrl (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    input  wire logic [scpr_pkg::IN_PAGE_BITS-1:0]    in_page,
    output logic                                      in_ready,
    input  wire logic                                 out_free,
    output logic                                      res_valid,
    output scpr_pkg::result_t                         res,
    output scpr_pkg::mem_req_t                        mem_req,
    input  wire scpr_pkg::page_t                      mem_rdata
);

    scpr_pkg::state_t  state_reg,   state_next;
    scpr_pkg::page_t   page_reg,    page_next;
    scpr_pkg::cnt_t    rd_idx_reg,  rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    scpr_pkg::slot_t   cmp_idx_reg, cmp_idx_next;
    logic [scpr_pkg::FRAMES-1:0] ref_reg, ref_next;
    scpr_pkg::cnt_t    filled_reg,  filled_next;
    scpr_pkg::slot_t   hand_reg,    hand_next;
    scpr_pkg::fault_t  fault_reg,   fault_next;
    scpr_pkg::result_t res_reg,     res_next;

    logic             match;
    logic             search_miss;
    logic             full;
    scpr_pkg::fault_t fault_inc;
    scpr_pkg::slot_t  fill_slot;
    scpr_pkg::slot_t  hand_adv;

    // The memory word compared in a cycle is the one addressed in the cycle before.
    assign match       = cmp_vld_reg && (mem_rdata == page_reg);
    assign search_miss = (filled_reg == '0) ||
                         (cmp_vld_reg && !match && (rd_idx_reg == filled_reg));
    assign full        = (filled_reg == scpr_pkg::CNT_BITS'(scpr_pkg::FRAMES));
    assign fault_inc   = (fault_reg == '1) ? fault_reg : fault_reg + 1'b1;
    assign fill_slot   = filled_reg[scpr_pkg::SLOT_BITS-1:0];
    assign hand_adv    = (hand_reg == scpr_pkg::SLOT_BITS'(scpr_pkg::FRAMES - 1)) ?
                         '0 : hand_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scpr_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = scpr_pkg::ST_SRCH;
                end
            end
            scpr_pkg::ST_SRCH: begin
                if (match) begin
                    state_next = scpr_pkg::ST_FIN;
                end else if (search_miss) begin
                    state_next = full ? scpr_pkg::ST_SWEEP : scpr_pkg::ST_FIN;
                end
            end
            scpr_pkg::ST_SWEEP: begin
                if (!ref_reg[hand_reg]) begin
                    state_next = scpr_pkg::ST_EVICT;
                end
            end
            scpr_pkg::ST_EVICT: begin
                state_next = scpr_pkg::ST_FIN;
            end
            scpr_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = scpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        page_next     = page_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        ref_next      = ref_reg;
        filled_next   = filled_reg;
        hand_next     = hand_reg;
        fault_next    = fault_reg;
        res_next      = res_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = hand_reg;
        mem_req.wdata = page_reg;
        mem_req.raddr = rd_idx_reg[scpr_pkg::SLOT_BITS-1:0];
        case (state_reg)
            scpr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    page_next    = scpr_pkg::page_of_word(in_page);
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                end
            end
            scpr_pkg::ST_SRCH: begin
                // Issue the next filled slot while comparing the previous one.
                if (rd_idx_reg < filled_reg) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[scpr_pkg::SLOT_BITS-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end else begin
                    cmp_vld_next = 1'b0;
                end
                if (match) begin
                    ref_next[cmp_idx_reg]  = 1'b1;
                    res_next.hit           = 1'b1;
                    res_next.evicted_valid = 1'b0;
                    res_next.evicted_page  = '0;
                    res_next.slot_index    = scpr_pkg::slot_field(cmp_idx_reg);
                    res_next.faults_so_far = fault_reg;
                end else if (search_miss && !full) begin
                    mem_req.we             = 1'b1;
                    mem_req.waddr          = fill_slot;
                    ref_next[fill_slot]    = 1'b1;
                    filled_next            = filled_reg + 1'b1;
                    fault_next             = fault_inc;
                    res_next.hit           = 1'b0;
                    res_next.evicted_valid = 1'b0;
                    res_next.evicted_page  = '0;
                    res_next.slot_index    = scpr_pkg::slot_field(fill_slot);
                    res_next.faults_so_far = fault_inc;
                end
            end
            scpr_pkg::ST_SWEEP: begin
                // The victim's page is read in the cycle the hand stops.
                mem_req.raddr = hand_reg;
                if (ref_reg[hand_reg]) begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_adv;
                end
            end
            scpr_pkg::ST_EVICT: begin
                mem_req.we             = 1'b1;
                mem_req.waddr          = hand_reg;
                ref_next[hand_reg]     = 1'b1;
                fault_next             = fault_inc;
                res_next.hit           = 1'b0;
                res_next.evicted_valid = 1'b1;
                res_next.evicted_page  = scpr_pkg::word_of_page(mem_rdata);
                res_next.slot_index    = scpr_pkg::slot_field(hand_reg);
                res_next.faults_so_far = fault_inc;
            end
            scpr_pkg::ST_FIN: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scpr_pkg::ST_IDLE;
            cmp_vld_reg <= 1'b0;
            ref_reg     <= '0;
            filled_reg  <= '0;
            hand_reg    <= '0;
            fault_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            ref_reg     <= ref_next;
            filled_reg  <= filled_next;
            hand_reg    <= hand_next;
            fault_reg   <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg    <= page_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/second_chance_page_replacer_top.sv =====
// Second-chance (clock) page replacer, top level. Depends on scpr_pkg, scpr_page_ram, scpr_ctrl.
// A miss with no slot filled passes from accept through ST_SRCH and ST_FIN to the output register;
// a full hit search, a sweep and an eviction also pass through ST_SWEEP and ST_EVICT.
// One word is handled at a time, paced by the one-read-per-cycle search of the slot memory and
// the one-slot-per-cycle clock sweep. A new word is taken while a result waits in the output register.
// Reset (aresetn, synchronous): reference bits, fill count, hand and fault count clear at once.
`default_nettype none

module second_chance_page_replacer_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: [15:0] page_number
    input  wire logic [scpr_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: [0] hit, [1] evicted_valid, [17:2] evicted_page, [19:18] slot_index,
    // [51:20] faults_so_far, [55:52] zero
    output logic [scpr_pkg::M_TDATA_BITS-1:0]      m_tdata
);

    logic                 out_free;
    logic                 res_valid;
    logic                 res_load;
    scpr_pkg::result_t    res;
    scpr_pkg::mem_req_t   mem_req;
    scpr_pkg::page_t      mem_rdata;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [scpr_pkg::M_TDATA_BITS-1:0] m_tdata_reg,  m_tdata_next;

    scpr_page_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    scpr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_page   (s_tdata[scpr_pkg::IN_PAGE_BITS-1:0]),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign res_load = res_valid && out_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{scpr_pkg::M_PAD_BITS{1'b0}}, res};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Once a word is taken the sequencer is busy in the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !(res.hit && res.evicted_valid))
        else $error("hit result carries an eviction");

    // Without an eviction the evicted page field is zero.
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && !res.evicted_valid) |-> (res.evicted_page == '0))
        else $error("evicted page nonzero without eviction");

endmodule

`default_nettype wire
